### hw/rtl/indexed_list_store_defines.svh
// indexed_list_store_defines.svh: assertion macros for the indexed list store
// no dependencies; included by files that carry concurrent checks
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define ILS_CHECK(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ILS_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ils_pkg.sv
// ils_pkg: shared types and constants for the indexed list store
// no dependencies; used by the channel interfaces, the ram and the top level
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

  // default sizing
  localparam int CAPACITY_DEF = 64;
  localparam int WORD_W_DEF   = 32;

  // fixed field widths on the channels
  localparam int IN_WORD_W = 32;
  localparam int POS_W     = 8;
  localparam int OUT_CNT_W = 7;

  // operation codes
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_INS,
    S_REM,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/ils_if.sv
// ils_if: valid/ready channel interfaces for requests and responses
// depends on ils_pkg for field widths and code types
`timescale 1ns / 1ps
`default_nettype none

interface ils_in_if;
  import ils_pkg::*;

  logic                     valid;
  logic                     ready;
  op_t                      op;
  logic signed [POS_W-1:0]  position;
  logic [IN_WORD_W-1:0]     word_in;

  modport source (output valid, output op, output position, output word_in, input ready);
  modport sink   (input valid, input op, input position, input word_in, output ready);
endinterface

interface ils_out_if;
  import ils_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [IN_WORD_W-1:0]  word_out;
  status_t               status;
  logic [OUT_CNT_W-1:0]  count_now;

  modport source (output valid, output word_out, output status, output count_now, input ready);
  modport sink   (input valid, input word_out, input status, input count_now, output ready);
endinterface

`default_nettype wire

### hw/rtl/indexed_list_store.sv
// channel    | dir | payload                          | meaning
// request    | in  | op, position, word_in            | one list operation
// response   | out | word_out, status, count_now      | one answer per request
//
// append and any rejected request go from accept through S_RESP to the output register; a read adds S_GET
// insert or remove at index i below count shifts through S_INS or S_REM; insert at count just writes in S_INS
// the shift moves one entry per cycle through the single ram read and write port
// rst (synchronous) empties the list at once; entries are not cleared
// a new request is taken once the previous answer sits in the output register
// indexed_list_store: ordered word list over one ram, shifted one entry per cycle
// depends on ils_pkg, ils_if, ils_ram and indexed_list_store_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_list_store_defines.svh"

module indexed_list_store #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF,
  parameter int WORD_W   = ils_pkg::WORD_W_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ils_in_if.sink    request,
  ils_out_if.source response
);
  import ils_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  // control registers
  state_t          state, state_next;
  logic [CW-1:0]   count;
  logic            pend;
  logic            out_valid;

  // payload registers
  logic [CW-1:0]           cursor;
  logic [CW-1:0]           at_idx;
  logic [WORD_W-1:0]       word_hold;
  logic [AW-1:0]           pend_addr;
  logic                    pend_take;
  logic [WORD_W-1:0]       res_word;
  status_t                 res_status;
  logic [IN_WORD_W-1:0]    out_word;
  status_t                 out_status;
  logic [OUT_CNT_W-1:0]    out_count;

  // ram ports
  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [WORD_W-1:0]  wdata, rd_data;

  // decode
  logic                         accept;
  logic signed [IW-1:0]         pos_ext, cnt_ext, idx_res;
  logic                         ins_ok, idx_ok, full;
  logic [CW-1:0]                idx_cnt, cur_dec;
  logic [IN_WORD_W+WORD_W-1:0]  win_ext;
  logic [WORD_W-1:0]            word_w;
  logic [WORD_W+IN_WORD_W-1:0]  rw_ext;
  logic [CW+OUT_CNT_W-1:0]      cnt_out_ext;
  logic                         ins_done, rem_done, resp_load;

  assign accept = request.valid && request.ready;
  assign request.ready = (state == S_IDLE);

  // resolve a signed position against the current count
  assign pos_ext = {{(IW-POS_W){request.position[POS_W-1]}}, request.position};
  assign cnt_ext = {{(IW-CW){1'b0}}, count};
  assign idx_res = request.position[POS_W-1] ? (pos_ext + cnt_ext) : pos_ext;
  assign ins_ok  = !idx_res[IW-1] && (idx_res <= cnt_ext);
  assign idx_ok  = !idx_res[IW-1] && (idx_res < cnt_ext);
  assign idx_cnt = idx_res[CW-1:0];
  assign full    = (count == CAP_CNT);
  assign cur_dec = cursor - CW'(1);

  // input word kept to the stored width
  assign win_ext = {{WORD_W{1'b0}}, request.word_in};
  assign word_w  = win_ext[WORD_W-1:0];

  assign ins_done  = (state == S_INS) && !pend && (cursor == at_idx);
  assign rem_done  = (state == S_REM) && !pend && (cursor == count);
  assign resp_load = (state == S_RESP) && (!out_valid || response.ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (request.op)
            OP_APPEND: state_next = S_RESP;
            OP_INSERT: state_next = (ins_ok && !full) ? S_INS : S_RESP;
            OP_REMOVE: state_next = idx_ok ? S_REM : S_RESP;
            OP_READ:   state_next = idx_ok ? S_GET : S_RESP;
            default:   state_next = S_RESP;
          endcase
        end
      end
      S_GET:   state_next = S_RESP;
      S_INS:   if (ins_done) state_next = S_RESP;
      S_REM:   if (rem_done) state_next = S_RESP;
      S_RESP:  if (resp_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ram access per state
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    case (state)
      S_IDLE: begin
        if (accept && request.op == OP_APPEND && !full) begin
          we    = 1'b1;
          waddr = count[AW-1:0];
          wdata = word_w;
        end
        if (accept && request.op == OP_READ && idx_ok) begin
          re    = 1'b1;
          raddr = idx_cnt[AW-1:0];
        end
      end
      S_INS: begin
        // move the word read last cycle one place up, then drop in the new word
        if (pend) begin
          we    = 1'b1;
          waddr = pend_addr;
          wdata = rd_data;
        end else if (cursor == at_idx) begin
          we    = 1'b1;
          waddr = at_idx[AW-1:0];
          wdata = word_hold;
        end
        if (cursor > at_idx) begin
          re    = 1'b1;
          raddr = cur_dec[AW-1:0];
        end
      end
      S_REM: begin
        // move the word read last cycle one place down
        if (pend && !pend_take) begin
          we    = 1'b1;
          waddr = pend_addr;
          wdata = rd_data;
        end
        if (cursor < count) begin
          re    = 1'b1;
          raddr = cursor[AW-1:0];
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= re && (state == S_INS || state == S_REM);
      if (state == S_IDLE && accept && request.op == OP_APPEND && !full) begin
        count <= count + CW'(1);
      end else if (ins_done) begin
        count <= count + CW'(1);
      end else if (rem_done) begin
        count <= count - CW'(1);
      end
      if (resp_load) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rw_ext      = {{IN_WORD_W{1'b0}}, res_word};
  assign cnt_out_ext = {{OUT_CNT_W{1'b0}}, count};

  // datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      at_idx    <= idx_cnt;
      word_hold <= word_w;
      res_word  <= '0;
      cursor    <= (request.op == OP_INSERT) ? count : idx_cnt;
      case (request.op)
        OP_APPEND: res_status <= full ? ST_FULL : ST_OK;
        OP_INSERT: res_status <= !ins_ok ? ST_RANGE : (full ? ST_FULL : ST_OK);
        default:   res_status <= idx_ok ? ST_OK : ST_RANGE;
      endcase
    end
    if (state == S_GET) begin
      res_word <= rd_data;
    end
    if (state == S_INS && re) begin
      cursor    <= cur_dec;
      pend_addr <= cursor[AW-1:0];
    end
    if (state == S_REM) begin
      if (pend && pend_take) begin
        res_word <= rd_data;
      end
      if (re) begin
        cursor    <= cursor + CW'(1);
        pend_addr <= cur_dec[AW-1:0];
        pend_take <= (cursor == at_idx);
      end
    end
    if (resp_load) begin
      out_word   <= rw_ext[IN_WORD_W-1:0];
      out_status <= res_status;
      out_count  <= cnt_out_ext[OUT_CNT_W-1:0];
    end
  end

  assign response.valid     = out_valid;
  assign response.word_out  = out_word;
  assign response.status    = out_status;
  assign response.count_now = out_count;

  // list storage
  ils_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // checks
  `ILS_CHECK(a_count_cap, clk, rst, 1'b1, count <= CAP_CNT, "fill count above capacity")
  `ILS_CHECK(a_idle_no_pend, clk, rst, state == S_IDLE, !pend, "shift pending while idle")
  `ILS_CHECK(a_err_word_zero, clk, rst, out_valid && out_status != ST_OK, out_word == '0, "error response carries a word")
  `ILS_CHECK_NEXT(a_resp_loads, clk, rst, state == S_RESP && !out_valid, out_valid, "response not loaded")

endmodule

`default_nettype wire

### hw/rtl/ils_ram.sv
// ils_ram: generic single-write, single-read ram with registered read data
// depends on ils_pkg for default sizing
`timescale 1ns / 1ps
`default_nettype none

module ils_ram #(
  parameter int WIDTH = ils_pkg::WORD_W_DEF,
  parameter int DEPTH = ils_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);
  import ils_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### tb/sv/indexed_list_store_tb.sv
// indexed_list_store_tb: self-checking bench for the indexed list store
// depends on ils_pkg, ils_if and indexed_list_store; predicts every response in-bench
`timescale 1ns / 1ps

module indexed_list_store_tb;
  import ils_pkg::*;

  localparam int LIST_CAP    = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_OPS  = 1150;
  localparam int PHASE_LEN   = 100;
  localparam int DRAIN_WAIT  = 100;

  typedef struct packed {
    op_t                  op;
    logic [POS_W-1:0]     position;
    logic [IN_WORD_W-1:0] word;
  } list_req_t;

  typedef struct packed {
    logic [IN_WORD_W-1:0] word;
    status_t              status;
    logic [OUT_CNT_W-1:0] count;
  } list_resp_t;

  // list build modes for the random part
  typedef enum int {
    MODE_FILL,
    MODE_MIXED,
    MODE_DRAIN
  } build_mode_t;

  logic clk = 1'b0;
  logic rst;

  ils_in_if  request_bus ();
  ils_out_if response_bus ();

  indexed_list_store u_top (
    .clk      (clk),
    .rst      (rst),
    .request  (request_bus),
    .response (response_bus)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  list_req_t  pending_reqs [$];
  list_resp_t expected_resps [$];

  // shadow list used while planning requests
  logic [IN_WORD_W-1:0] plan_slots [LIST_CAP];
  int                   plan_fill;

  // shadow list advanced on each accepted request
  logic [IN_WORD_W-1:0] list_slots [LIST_CAP];
  int                   list_fill;

  list_req_t driven_req;
  int        sent_count;
  int        rcvd_count;
  int        err_count;
  int        cycles;

  // apply one list operation to a shadow list and produce its response
  function automatic void apply_list_op(ref logic [IN_WORD_W-1:0] slots [LIST_CAP],
                                        ref int fill, input list_req_t rq,
                                        output list_resp_t rs);
    int idx;
    int k;
    rs.word   = '0;
    rs.status = ST_OK;
    idx = int'($signed(rq.position));
    if (idx < 0) begin
      idx += fill;
    end
    case (rq.op)
      OP_APPEND: begin
        if (fill >= LIST_CAP) begin
          rs.status = ST_FULL;
        end else begin
          slots[fill] = rq.word;
          fill++;
        end
      end
      OP_INSERT: begin
        // range check wins over the full check
        if (idx < 0 || idx > fill) begin
          rs.status = ST_RANGE;
        end else if (fill >= LIST_CAP) begin
          rs.status = ST_FULL;
        end else begin
          for (k = fill; k > idx; k--) begin
            slots[k] = slots[k-1];
          end
          slots[idx] = rq.word;
          fill++;
        end
      end
      default: begin
        if (idx < 0 || idx >= fill) begin
          rs.status = ST_RANGE;
        end else begin
          rs.word = slots[idx];
          if (rq.op == OP_REMOVE) begin
            for (k = idx; k + 1 < fill; k++) begin
              slots[k] = slots[k+1];
            end
            fill--;
          end
        end
      end
    endcase
    rs.count = OUT_CNT_W'(fill);
  endfunction

  // queue one request and advance the planning copy of the list
  task automatic plan_request(input op_t op, input logic [POS_W-1:0] pos,
                              input logic [IN_WORD_W-1:0] w);
    list_req_t  rq;
    list_resp_t unused;
    rq.op       = op;
    rq.position = pos;
    rq.word     = w;
    pending_reqs.push_back(rq);
    apply_list_op(plan_slots, plan_fill, rq, unused);
  endtask

  // stall odds in percent: phase 0 none, 1 sender, 2 receiver, 3 both lightly
  function automatic int sender_idle_pct(input int n);
    case ((n / PHASE_LEN) % 4)
      1:       return 63;
      3:       return 21;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(input int n);
    case ((n / PHASE_LEN) % 4)
      2:       return 63;
      3:       return 21;
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int n,
                                 input logic [IN_WORD_W-1:0] got,
                                 input logic [IN_WORD_W-1:0] want);
    if (err_count < 40) begin
      $display("[%0t] response %0d: %s got %0h expected %0h", $time, n, field, got, want);
    end
    err_count++;
  endtask

  // request driver: predicts on accept, then presents the next request
  always @(posedge clk) begin : drive_requests
    list_resp_t rs;
    if (rst) begin
      request_bus.valid <= 1'b0;
    end else begin
      if (request_bus.valid && request_bus.ready) begin
        apply_list_op(list_slots, list_fill, driven_req, rs);
        expected_resps.push_back(rs);
        sent_count++;
      end
      if (!request_bus.valid || request_bus.ready) begin
        if (pending_reqs.size() != 0 &&
            $urandom_range(99) >= sender_idle_pct(sent_count)) begin
          driven_req = pending_reqs.pop_front();
          request_bus.valid    <= 1'b1;
          request_bus.op       <= driven_req.op;
          request_bus.position <= driven_req.position;
          request_bus.word_in  <= driven_req.word;
        end else begin
          request_bus.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor: compares against the oldest prediction
  always @(posedge clk) begin : check_responses
    list_resp_t want;
    if (rst) begin
      response_bus.ready <= 1'b0;
    end else begin
      if (response_bus.valid && response_bus.ready) begin
        if (expected_resps.size() == 0) begin
          report_mismatch("unexpected response, word", rcvd_count,
                          response_bus.word_out, '0);
        end else begin
          want = expected_resps.pop_front();
          if (response_bus.word_out !== want.word) begin
            report_mismatch("word_out", rcvd_count, response_bus.word_out, want.word);
          end
          if (response_bus.status !== want.status) begin
            report_mismatch("status", rcvd_count, response_bus.status, want.status);
          end
          if (response_bus.count_now !== want.count) begin
            report_mismatch("count_now", rcvd_count, response_bus.count_now, want.count);
          end
        end
        rcvd_count++;
      end
      response_bus.ready <= ($urandom_range(99) >= receiver_stall_pct(rcvd_count));
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("indexed_list_store_tb: FAIL");
      $finish;
    end
  end

  // random word with extra weight on all zeros and all ones
  function automatic logic [IN_WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // mostly a legal index for the current size, sometimes any raw byte
  function automatic logic [POS_W-1:0] pick_position(input op_t op, input int fill);
    int top;
    int r;
    int p;
    top = (op == OP_INSERT) ? fill : fill - 1;
    if (top < 0 || $urandom_range(99) < 15) begin
      return POS_W'($urandom_range(255));
    end
    r = $urandom_range(top);
    if ($urandom_range(1) == 1 && r < fill) begin
      p = r - fill;
    end else begin
      p = r;
    end
    return p[POS_W-1:0];
  endfunction

  function automatic op_t pick_op(input build_mode_t mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        if (r < 45) return OP_APPEND;
        if (r < 85) return OP_INSERT;
        if (r < 90) return OP_REMOVE;
        return OP_READ;
      end
      MODE_DRAIN: begin
        if (r < 5) return OP_APPEND;
        if (r < 10) return OP_INSERT;
        if (r < 85) return OP_REMOVE;
        return OP_READ;
      end
      default: begin
        if (r < 25) return OP_APPEND;
        if (r < 50) return OP_INSERT;
        if (r < 75) return OP_REMOVE;
        return OP_READ;
      end
    endcase
  endfunction

  // stimulus and end of run
  initial begin : stimulus
    build_mode_t mode;
    int          seg_left;
    int          seg_idx;
    int          n;
    op_t         op;

    rst = 1'b1;
    request_bus.valid    = 1'b0;
    request_bus.op       = OP_APPEND;
    request_bus.position = '0;
    request_bus.word_in  = '0;
    response_bus.ready   = 1'b0;
    cycles     = 0;
    sent_count = 0;
    rcvd_count = 0;
    err_count  = 0;
    plan_fill  = 0;
    list_fill  = 0;

    // each of these indexes is out of range on an empty list
    plan_request(OP_READ,   8'sd0,   32'h1111_1111);
    plan_request(OP_REMOVE, -8'sd1,  32'h2222_2222);
    plan_request(OP_INSERT, 8'sd1,   32'h3333_3333);
    plan_request(OP_INSERT, -8'sd1,  32'h4444_4444);
    // insert at the end of an empty list, then appends
    plan_request(OP_INSERT, 8'sd0,   32'hFFFF_FFFF);
    plan_request(OP_APPEND, 8'sd0,   32'h0000_0000);
    plan_request(OP_APPEND, 8'h55,   32'hA5A5_A5A5);
    // extreme indexes are rejected
    plan_request(OP_INSERT, 8'h80,   32'hDEAD_BEEF);
    plan_request(OP_INSERT, 8'h7F,   32'hDEAD_BEEF);
    // insert at count lands at the end, negative count lands at the front
    plan_request(OP_INSERT, 8'sd3,   32'h5A5A_5A5A);
    plan_request(OP_INSERT, -8'sd4,  32'h0123_4567);
    // reads at the edges of the valid range
    plan_request(OP_READ,   -8'sd1,  32'h0);
    plan_request(OP_READ,   8'sd5,   32'h0);
    plan_request(OP_READ,   -8'sd5,  32'h0);
    plan_request(OP_READ,   -8'sd6,  32'h0);
    plan_request(OP_READ,   8'h80,   32'h0);
    // removes from the middle, the end and the front, one out of range, then an append
    plan_request(OP_REMOVE, 8'sd2,   32'h0);
    plan_request(OP_REMOVE, -8'sd1,  32'h0);
    plan_request(OP_REMOVE, 8'sd0,   32'h0);
    plan_request(OP_REMOVE, 8'h7F,   32'h0);
    plan_request(OP_APPEND, 8'hAA,   32'h8000_0001);

    // random part: alternate segments that grow the list, mix operations, and drain the list
    seg_idx  = 0;
    seg_left = 0;
    mode     = MODE_FILL;
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (seg_left == 0) begin
        case (seg_idx % 4)
          0:       mode = MODE_FILL;
          2:       mode = MODE_DRAIN;
          default: mode = MODE_MIXED;
        endcase
        seg_left = $urandom_range(110, 60);
        seg_idx++;
      end
      op = pick_op(mode);
      plan_request(op, pick_position(op, plan_fill), pick_word());
      seg_left--;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // all requests accepted, then all responses in, then a quiet tail
    while (pending_reqs.size() != 0 || request_bus.valid) begin
      @(posedge clk);
    end
    while (expected_resps.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0) begin
      $display("indexed_list_store_tb: PASS");
    end else begin
      $display("indexed_list_store_tb: FAIL");
    end
    $finish;
  end

endmodule
